// ===== design/npcs_pkg.sv =====
// Shared types, widths and helpers for the nearest palette colour search.
package npcs_pkg;

  localparam int unsigned PAL_ENTRIES_DEF = 256;
  localparam int unsigned IDX_W           = 8;
  localparam int unsigned COMP_W          = 8;
  localparam int unsigned ENTRY_W         = 3 * COMP_W;
  localparam int unsigned QCOLOR_W        = 15;
  localparam int unsigned QCOMP_W         = 5;
  localparam int unsigned SQ_W            = 2 * COMP_W;
  localparam int unsigned DIST_W          = 18;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] sq_dist;
  } dist_t;

  // Widen a 5-bit component to 8 bits as value*8+4.
  function automatic logic [COMP_W-1:0] widen(input logic [QCOMP_W-1:0] v);
    return {v, 3'b100};
  endfunction

endpackage

// ===== design/npcs_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module npcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== design/npcs_dist.sv =====
// Two-stage squared-distance unit: per-component squares, then their sum.
module npcs_dist
  import npcs_pkg::*;
#(
  parameter int unsigned AW = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [COMP_W-1:0]  qr_i,
  input  logic [COMP_W-1:0]  qg_i,
  input  logic [COMP_W-1:0]  qb_i,
  input  logic               rd_vld_i,
  input  logic [AW-1:0]      rd_idx_i,
  input  logic [ENTRY_W-1:0] rdata_i,
  output dist_t              dist_o
);

  logic [COMP_W-1:0] dr, dg, db;
  logic [SQ_W-1:0]   sqr_q, sqg_q, sqb_q;
  logic              s1_vld_q;
  logic [AW-1:0]     s1_idx_q;
  logic              dist_vld_q;
  logic [IDX_W-1:0]  dist_idx_q;
  logic [DIST_W-1:0] dist_sq_q;

  function automatic logic [COMP_W-1:0] absdiff(input logic [COMP_W-1:0] a,
                                                input logic [COMP_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  assign dr = absdiff(qr_i, rdata_i[3*COMP_W-1:2*COMP_W]);
  assign dg = absdiff(qg_i, rdata_i[2*COMP_W-1:COMP_W]);
  assign db = absdiff(qb_i, rdata_i[COMP_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      dist_vld_q <= 1'b0;
    end else begin
      s1_vld_q   <= rd_vld_i;
      dist_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sqr_q      <= SQ_W'(dr) * SQ_W'(dr);
    sqg_q      <= SQ_W'(dg) * SQ_W'(dg);
    sqb_q      <= SQ_W'(db) * SQ_W'(db);
    s1_idx_q   <= rd_idx_i;
    dist_idx_q <= IDX_W'(s1_idx_q);
    dist_sq_q  <= DIST_W'(sqr_q) + DIST_W'(sqg_q) + DIST_W'(sqb_q);
  end

  assign dist_o = {dist_vld_q, dist_idx_q, dist_sq_q};

endmodule

// ===== design/nearest_palette_color_search.sv =====
// A query result passes the palette RAM read register, both distance stages and the
// ST_FINISH state, then is registered at the output; the input stays stalled until then,
// and the single palette read port reads one entry per cycle. A load gives no result.
// Reset: a clearing pass zeroes the palette RAM, input stalled.
// The next transaction is taken while a finished result waits in the output register.
module nearest_palette_color_search
  import npcs_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                mode_i,
  input  logic [IDX_W-1:0]    entry_index_i,
  input  logic [COMP_W-1:0]   red_i,
  input  logic [COMP_W-1:0]   green_i,
  input  logic [COMP_W-1:0]   blue_i,
  input  logic [QCOLOR_W-1:0] query_color_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [IDX_W-1:0]    best_index_o,
  output logic [DIST_W-1:0]   best_distance_o
);

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(PALETTE_ENTRIES - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);
  localparam logic [IDX_W:0] IDX_LIMIT = (IDX_W + 1)'(PALETTE_ENTRIES);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       cnt_q, cnt_d;
  logic                issuing_q, issuing_d;
  logic                rd_vld_q;
  logic [AW-1:0]       rd_idx_q;
  logic                out_valid_q, out_valid_d;
  logic [IDX_W-1:0]    out_idx_q, out_idx_d;
  logic [DIST_W-1:0]   out_dist_q, out_dist_d;
  logic [COMP_W-1:0]   qr_q, qg_q, qb_q;
  logic [IDX_W-1:0]    best_i_q;
  logic [DIST_W-1:0]   best_d_q;

  logic                in_acc;
  logic                load_acc;
  logic                query_acc;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [ENTRY_W-1:0]  wdata;
  logic                re;
  logic [ENTRY_W-1:0]  rdata;
  dist_t               cand;
  logic                take_best;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_acc   = in_acc && (mode_i == MODE_LOAD);
  assign query_acc  = in_acc && (mode_i == MODE_QUERY);

  // Write port: zero fill during clearing, otherwise in-range loads.
  always_comb begin
    we    = 1'b0;
    waddr = entry_index_i[AW-1:0];
    wdata = {red_i, green_i, blue_i};
    if (state_q == ST_CLEAR) begin
      we    = 1'b1;
      waddr = cnt_q;
      wdata = '0;
    end else if (load_acc && ({1'b0, entry_index_i} < IDX_LIMIT)) begin
      we = 1'b1;
    end
  end

  assign re = issuing_q;

  npcs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (cnt_q),
    .rdata_o (rdata)
  );

  npcs_dist #(
    .AW (AW)
  ) u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .qr_i     (qr_q),
    .qg_i     (qg_q),
    .qb_i     (qb_q),
    .rd_vld_i (rd_vld_q),
    .rd_idx_i (rd_idx_q),
    .rdata_i  (rdata),
    .dist_o   (cand)
  );

  // Strict compare keeps the lowest index on a tie.
  assign take_best = cand.vld && ((cand.idx == '0) || (cand.sq_dist < best_d_q));

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    issuing_d   = issuing_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_idx_d   = out_idx_q;
    out_dist_d  = out_dist_q;
    case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == LAST) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (query_acc) begin
          cnt_d     = '0;
          issuing_d = 1'b1;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issuing_q) begin
          if (cnt_q == LAST) begin
            issuing_d = 1'b0;
          end else begin
            cnt_d = cnt_q + AW'(1);
          end
        end
        if (cand.vld && (cand.idx == LAST_IDX)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_idx_d   = best_i_q;
          out_dist_d  = best_d_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      issuing_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_dist_q  <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      issuing_q   <= issuing_d;
      rd_vld_q    <= issuing_q;
      out_valid_q <= out_valid_d;
      out_idx_q   <= out_idx_d;
      out_dist_q  <= out_dist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
    if (query_acc) begin
      qr_q <= widen(query_color_i[4:0]);
      qg_q <= widen(query_color_i[9:5]);
      qb_q <= widen(query_color_i[14:10]);
    end
    if (take_best) begin
      best_i_q <= cand.idx;
      best_d_q <= cand.sq_dist;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign best_index_o    = out_idx_q;
  assign best_distance_o = out_dist_q;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the nearest palette colour search block.
`timescale 1ns / 100ps

module tb;
  import npcs_pkg::*;

  localparam int unsigned NUM_ENTRIES   = PAL_ENTRIES_DEF;
  localparam int unsigned RANDOM_ITEMS  = 1430;
  localparam int unsigned HOLD_CYCLES   = 1500;
  localparam int unsigned QUIET_LIMIT   = 12000;
  localparam int unsigned DRAIN_CYCLES  = NUM_ENTRIES + 150;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] sq_dist;
  } color_match_t;

  typedef struct {
    logic                mode;
    logic [IDX_W-1:0]    idx;
    logic [COMP_W-1:0]   r;
    logic [COMP_W-1:0]   g;
    logic [COMP_W-1:0]   b;
    logic [QCOLOR_W-1:0] qc;
    bit                  fixed;
    color_match_t        fixed_match;
  } palette_op_t;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                mode          = MODE_LOAD;
  logic [IDX_W-1:0]    entry_index   = '0;
  logic [COMP_W-1:0]   red           = '0;
  logic [COMP_W-1:0]   green         = '0;
  logic [COMP_W-1:0]   blue          = '0;
  logic [QCOLOR_W-1:0] query_color   = '0;
  logic                out_stall     = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [IDX_W-1:0]    best_index;
  logic [DIST_W-1:0]   best_distance;

  // Shadow palette kept in step with accepted loads
  logic [COMP_W-1:0] shadow_red   [NUM_ENTRIES];
  logic [COMP_W-1:0] shadow_green [NUM_ENTRIES];
  logic [COMP_W-1:0] shadow_blue  [NUM_ENTRIES];

  color_match_t pending_matches[$];
  palette_op_t  directed_ops[$];
  int unsigned  fail_count = 0;
  int unsigned  quiet_cycles = 0;
  bit           hold_req = 1'b0;

  nearest_palette_color_search uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .mode_i          (mode),
    .entry_index_i   (entry_index),
    .red_i           (red),
    .green_i         (green),
    .blue_i          (blue),
    .query_color_i   (query_color),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .best_index_o    (best_index),
    .best_distance_o (best_distance)
  );

  always #5 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 80) return $urandom_range(1, 3);
    if (p < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  function automatic int unsigned sq_gap(input int unsigned a, input int unsigned b);
    int d;
    d = int'(a) - int'(b);
    return d * d;
  endfunction

  // Scan the shadow palette for the closest entry; strict less-than keeps the lowest index
  function automatic color_match_t nearest_entry(input logic [QCOLOR_W-1:0] qc);
    int unsigned  qr, qg, qb, d, best_d;
    color_match_t m;
    qr = qc[4:0] * 8 + 4;
    qg = qc[9:5] * 8 + 4;
    qb = qc[14:10] * 8 + 4;
    best_d = 0;
    m.idx = '0;
    for (int unsigned i = 0; i < NUM_ENTRIES; i++) begin
      d = sq_gap(qr, shadow_red[i]) + sq_gap(qg, shadow_green[i]) +
          sq_gap(qb, shadow_blue[i]);
      if (i == 0 || d < best_d) begin
        best_d = d;
        m.idx  = i[IDX_W-1:0];
      end
    end
    m.sq_dist = best_d[DIST_W-1:0];
    return m;
  endfunction

  task automatic note_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic add_op(input logic m, input logic [IDX_W-1:0] idx,
                        input logic [COMP_W-1:0] r, input logic [COMP_W-1:0] g,
                        input logic [COMP_W-1:0] b, input logic [QCOLOR_W-1:0] qc,
                        input int unsigned fixed, input int unsigned f_idx,
                        input int unsigned f_dist);
    palette_op_t op;
    op.mode = m;
    op.idx = idx;
    op.r = r;
    op.g = g;
    op.b = b;
    op.qc = qc;
    op.fixed = (fixed != 0);
    op.fixed_match.idx = f_idx[IDX_W-1:0];
    op.fixed_match.sq_dist = f_dist[DIST_W-1:0];
    directed_ops.push_back(op);
  endtask

  // Offer one transaction after a random gap and hold it until accepted,
  // then update the shadow palette or queue the expected match
  task automatic send_op(input palette_op_t op);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= op.mode;
    entry_index <= op.idx;
    red         <= op.r;
    green       <= op.g;
    blue        <= op.b;
    query_color <= op.qc;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (op.mode == MODE_LOAD) begin
      if (op.idx < NUM_ENTRIES) begin
        shadow_red[op.idx]   = op.r;
        shadow_green[op.idx] = op.g;
        shadow_blue[op.idx]  = op.b;
      end
    end else if (op.fixed) begin
      pending_matches.push_back(op.fixed_match);
    end else begin
      pending_matches.push_back(nearest_entry(op.qc));
    end
  endtask

  function automatic logic [COMP_W-1:0] rand_comp();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 45) return {5'($urandom_range(0, 31)), 3'b100};
    if (p < 55) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic palette_op_t rand_op();
    palette_op_t op;
    int unsigned j, p;
    logic [COMP_W-1:0] cr, cg, cb;
    op.fixed = 1'b0;
    op.fixed_match.idx = '0;
    op.fixed_match.sq_dist = '0;
    op.idx = 8'($urandom_range(0, 255));
    op.r = 8'($urandom_range(0, 255));
    op.g = 8'($urandom_range(0, 255));
    op.b = 8'($urandom_range(0, 255));
    op.qc = 15'($urandom_range(0, 32767));
    // Hot entries are drawn from a small set so ties and overwrites are frequent
    j = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 15) : $urandom_range(0, 255);
    if ($urandom_range(0, 99) < 50) begin
      op.mode = MODE_LOAD;
      op.idx = j[IDX_W-1:0];
      if ($urandom_range(0, 99) < 15) begin
        p = $urandom_range(0, NUM_ENTRIES - 1);
        op.r = shadow_red[p];
        op.g = shadow_green[p];
        op.b = shadow_blue[p];
      end else begin
        op.r = rand_comp();
        op.g = rand_comp();
        op.b = rand_comp();
      end
    end else begin
      op.mode = MODE_QUERY;
      p = $urandom_range(0, 2);
      if (p == 1) begin
        op.qc = {shadow_blue[j][7:3], shadow_green[j][7:3], shadow_red[j][7:3]};
      end else if (p == 2) begin
        cr = rand_comp();
        cg = rand_comp();
        cb = rand_comp();
        op.qc = {cb[7:3], cg[7:3], cr[7:3]};
      end
    end
    return op;
  endfunction

  // Receiver back-pressure: random stalls and free runs, plus one long hold-off
  int unsigned stall_left = 0;
  int unsigned free_left  = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;

  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (free_left != 0) begin
      free_left--;
      out_stall <= 1'b0;
    end else begin
      free_left  = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 4) :
                                                  $urandom_range(20, 120);
      stall_left = pick_gap();
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest expected match
  always @(posedge clk) begin
    color_match_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_matches.size() == 0) begin
        note_mismatch($sformatf("unexpected result: index %0d distance %0d",
                                best_index, best_distance));
      end else begin
        want = pending_matches.pop_front();
        if (best_index !== want.idx || best_distance !== want.sq_dist)
          note_mismatch($sformatf("match differs: want index %0d distance %0d, got %0d %0d",
                                  want.idx, want.sq_dist, best_index, best_distance));
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("nearest_palette_color_search regression: fail");
      $finish;
    end
  end

  initial begin
    palette_op_t op;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      shadow_red[i]   = '0;
      shadow_green[i] = '0;
      shadow_blue[i]  = '0;
    end

    // Fresh palette first, then extremes, exact hits and ties
    add_op(MODE_QUERY, 8'hA5, 8'h5A, 8'hFF, 8'h00, 15'h0000, 1, 0, 48);
    add_op(MODE_QUERY, 8'h3C, 8'hFF, 8'h00, 8'hFF, 15'h7FFF, 1, 0, 190512);
    add_op(MODE_LOAD,  8'd255, 8'd255, 8'd255, 8'd255, 15'h7FFF, 0, 0, 0);
    add_op(MODE_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 15'h7FFF, 1, 255, 27);
    add_op(MODE_LOAD,  8'd0, 8'd4, 8'd4, 8'd4, 15'h2AAA, 0, 0, 0);
    add_op(MODE_QUERY, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 15'h0000, 1, 0, 0);
    add_op(MODE_LOAD,  8'd1, 8'd4, 8'd4, 8'd4, 15'h5555, 0, 0, 0);
    add_op(MODE_QUERY, 8'h01, 8'h04, 8'h04, 8'h04, 15'h0000, 1, 0, 0);
    add_op(MODE_LOAD,  8'd200, 8'd255, 8'd0, 8'd0, 15'h0000, 0, 0, 0);
    add_op(MODE_QUERY, 8'hC8, 8'h00, 8'h00, 8'h00, 15'h001F, 1, 200, 41);
    add_op(MODE_LOAD,  8'd100, 8'd0, 8'd255, 8'd0, 15'h7FFF, 0, 0, 0);
    add_op(MODE_QUERY, 8'h64, 8'h80, 8'h80, 8'h80, 15'h03E0, 1, 100, 41);
    add_op(MODE_LOAD,  8'd50, 8'd0, 8'd0, 8'd255, 15'h1111, 0, 0, 0);
    add_op(MODE_QUERY, 8'h32, 8'h11, 8'h22, 8'h33, 15'h7C00, 1, 50, 41);
    add_op(MODE_LOAD,  8'd10, 8'd132, 8'd132, 8'd132, 15'h0000, 0, 0, 0);
    add_op(MODE_QUERY, 8'h0A, 8'h00, 8'h00, 8'h00, 15'h4210, 1, 10, 0);
    add_op(MODE_LOAD,  8'd20, 8'd130, 8'd132, 8'd132, 15'h0000, 0, 0, 0);
    add_op(MODE_LOAD,  8'd21, 8'd134, 8'd132, 8'd132, 15'h0000, 0, 0, 0);
    add_op(MODE_LOAD,  8'd10, 8'd0, 8'd0, 8'd0, 15'h7FFF, 0, 0, 0);
    add_op(MODE_QUERY, 8'h15, 8'hFF, 8'hFF, 8'hFF, 15'h4210, 1, 20, 4);
    add_op(MODE_LOAD,  8'd7, 8'd128, 8'd64, 8'd32, 15'h0000, 0, 0, 0);
    add_op(MODE_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 15'h1234, 0, 0, 0);
    add_op(MODE_LOAD,  8'd128, 8'h80, 8'h7F, 8'h01, 15'h0000, 0, 0, 0);
    add_op(MODE_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 15'h6B5A, 0, 0, 0);
    add_op(MODE_QUERY, 8'h00, 8'h00, 8'h00, 8'h00, 15'h3DEF, 0, 0, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_ops[i]) send_op(directed_ops[i]);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      // Hold the receiver off mid-run so the block fills up and stalls its input
      if (n == RANDOM_ITEMS / 2) hold_req = 1'b1;
      op = rand_op();
      send_op(op);
    end
    in_valid <= 1'b0;

    while (pending_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("nearest_palette_color_search regression: pass");
    else
      $display("nearest_palette_color_search regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
design/npcs_pkg.sv
design/npcs_ram.sv
design/npcs_dist.sv
design/nearest_palette_color_search.sv
dv/tb.sv
